/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/tepc_pkg.sv */
package tepc_pkg;

  localparam int unsigned TILE_ROWS    = 8;
  localparam int unsigned TILE_COLUMNS = 32;
  localparam int unsigned ROW_BYTES    = 16;
  localparam int unsigned SCALE_BASE   = 128;
  localparam logic [7:0]  HIGH_NIBBLE  = 8'hF0;

  localparam int unsigned DIM_W       = 16;
  localparam int unsigned ROW_REM_W   = $clog2(TILE_ROWS);
  localparam int unsigned COL_REM_W   = $clog2(TILE_COLUMNS);
  localparam int unsigned ROW_TILE_W  = DIM_W - ROW_REM_W + 1;
  localparam int unsigned GROUP_W     = DIM_W - COL_REM_W + 1;
  localparam int unsigned COL_IDX_W   = $clog2(ROW_BYTES);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_ROW_PAD = 3'd2,
    ST_K_PAD   = 3'd3,
    ST_ODD     = 3'd4
  } status_t;

  typedef enum logic {
    REG_MATRIX_ROWS    = 1'b0,
    REG_MATRIX_COLUMNS = 1'b1
  } reg_idx_t;

endpackage

/* rtl/core/tepc_if.sv */
interface tepc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tepc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

interface tepc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/tile_edge_padding_checker_top.sv */
// Flow: a beat is registered in the input register on acceptance and checked there;
// the status of a last beat is registered when that beat leaves the input register.
// Throughput: one beat per cycle; a last beat waits in the input register
// only while the previous status is still held by the sink.
// Reset: synchronous, active low; clears the walk, the fault state, the
// matrix size registers and both pipeline valids.
`include "assert_macros.svh"

module tile_edge_padding_checker_top #(
  parameter int unsigned TILE_BYTES = 136
) (
  input  logic        clk,
  input  logic        rst_n,
  tepc_in_if.sink     in_bus,
  tepc_out_if.source  out_bus,
  tepc_cfg_if.sink    cfg_bus
);

  localparam int unsigned BW = $clog2(TILE_BYTES);
  localparam logic [BW-1:0] SCALE_LO  = BW'(tepc_pkg::SCALE_BASE);
  localparam logic [BW-1:0] SCALE_END = BW'(tepc_pkg::SCALE_BASE + tepc_pkg::TILE_ROWS);
  localparam logic [BW:0]   TILE_END  = (BW+1)'(TILE_BYTES);

  localparam int unsigned RRW = tepc_pkg::ROW_REM_W;
  localparam int unsigned CRW = tepc_pkg::COL_REM_W;
  localparam int unsigned RTW = tepc_pkg::ROW_TILE_W;
  localparam int unsigned GW  = tepc_pkg::GROUP_W;
  localparam int unsigned CIW = tepc_pkg::COL_IDX_W;

  logic [15:0] rows_r, cols_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_fire;

  logic        out_valid_r;
  tepc_pkg::status_t status_r;

  logic [BW-1:0]  byte_r, byte_nxt;
  logic [RTW-1:0] rt_idx_r, rt_idx_nxt;
  logic [GW-1:0]  grp_r, grp_nxt;
  logic           row_k_r, row_k_nxt;
  logic           row_odd_r, row_odd_nxt;
  logic           walk_done_r, walk_done_nxt;
  tepc_pkg::status_t first_fault_r, first_fault_nxt;
  tepc_pkg::status_t tile_fault_r, tile_fault_nxt;
  tepc_pkg::status_t status_nxt;

  logic [RRW-1:0] row_rem;
  logic [CRW-1:0] col_rem;
  logic [RTW-1:0] rt_total;
  logic [GW-1:0]  groups;
  logic           done_pre, rt_at_edge, grp_at_edge, check_en, used_row;
  logic [CRW-1:0] used_cols;
  logic [RRW-1:0] rr;
  logic [CIW-1:0] col;
  logic [BW:0]    byte_inc;

  // config port
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      cols_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        tepc_pkg::REG_MATRIX_ROWS:    rows_r <= cfg_bus.data;
        tepc_pkg::REG_MATRIX_COLUMNS: cols_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_fire      = s1_valid_r && (!s1_last_r || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last;
    end
  end

  // geometry
  assign row_rem     = rows_r[RRW-1:0];
  assign col_rem     = cols_r[CRW-1:0];
  assign rt_total    = RTW'(rows_r[15:RRW]) + RTW'(|row_rem);
  assign groups      = GW'(cols_r[15:CRW]) + GW'(|col_rem);
  assign done_pre    = walk_done_r || (rt_idx_r >= rt_total) || (grp_r >= groups);
  assign rt_at_edge  = (|row_rem) && (rt_idx_r + RTW'(1) == rt_total);
  assign grp_at_edge = (|col_rem) && (grp_r + GW'(1) == groups);
  assign check_en    = !done_pre && (rt_at_edge || grp_at_edge);
  assign used_cols   = CRW'(({1'b0, col_rem} + (CRW+1)'(1)) >> 1);
  assign rr          = (byte_r < SCALE_LO) ? byte_r[CIW +: RRW] : byte_r[RRW-1:0];
  assign col         = byte_r[CIW-1:0];
  assign used_row    = !rt_at_edge || (rr < row_rem);
  assign byte_inc    = {1'b0, byte_r} + (BW+1)'(1);

  always_comb begin
    byte_nxt        = byte_r;
    rt_idx_nxt      = rt_idx_r;
    grp_nxt         = grp_r;
    row_k_nxt       = row_k_r;
    row_odd_nxt     = row_odd_r;
    walk_done_nxt   = walk_done_r;
    first_fault_nxt = first_fault_r;
    tile_fault_nxt  = tile_fault_r;
    status_nxt      = tepc_pkg::ST_OK;

    if (check_en) begin
      if (byte_r < SCALE_LO) begin
        if (!used_row) begin
          if (s1_byte_r != 8'd0 && tile_fault_nxt == tepc_pkg::ST_OK)
            tile_fault_nxt = tepc_pkg::ST_ROW_PAD;
        end else begin
          if (grp_at_edge) begin
            if (CRW'(col) >= used_cols && s1_byte_r != 8'd0)
              row_k_nxt = 1'b1;
            if (col_rem[0] && CRW'(col) + CRW'(1) == used_cols &&
                (s1_byte_r & tepc_pkg::HIGH_NIBBLE) != 8'd0)
              row_odd_nxt = 1'b1;
          end
          if (&col) begin
            if (tile_fault_nxt == tepc_pkg::ST_OK) begin
              if (row_k_nxt)
                tile_fault_nxt = tepc_pkg::ST_K_PAD;
              else if (row_odd_nxt)
                tile_fault_nxt = tepc_pkg::ST_ODD;
            end
            row_k_nxt   = 1'b0;
            row_odd_nxt = 1'b0;
          end
        end
      end else if (byte_r < SCALE_END) begin
        if (!used_row && s1_byte_r != 8'd0 && tile_fault_nxt == tepc_pkg::ST_OK)
          tile_fault_nxt = tepc_pkg::ST_ROW_PAD;
      end
    end

    if (!done_pre) begin
      byte_nxt = byte_inc[BW-1:0];
      if (byte_inc >= TILE_END) begin
        byte_nxt = '0;
        if (first_fault_nxt == tepc_pkg::ST_OK)
          first_fault_nxt = tile_fault_nxt;
        tile_fault_nxt = tepc_pkg::ST_OK;
        row_k_nxt      = 1'b0;
        row_odd_nxt    = 1'b0;
        grp_nxt        = grp_r + GW'(1);
        if (grp_nxt >= groups) begin
          grp_nxt    = '0;
          rt_idx_nxt = rt_idx_r + RTW'(1);
          if (rt_idx_nxt >= rt_total)
            walk_done_nxt = 1'b1;
        end
      end
    end

    status_nxt = first_fault_nxt;
    if (status_nxt == tepc_pkg::ST_OK && !(done_pre || walk_done_nxt) &&
        ((|row_rem) || (|col_rem)))
      status_nxt = tepc_pkg::ST_OUTSIDE;

    // end of payload: back to the start of a walk
    if (s1_last_r) begin
      byte_nxt        = '0;
      rt_idx_nxt      = '0;
      grp_nxt         = '0;
      row_k_nxt       = 1'b0;
      row_odd_nxt     = 1'b0;
      walk_done_nxt   = 1'b0;
      first_fault_nxt = tepc_pkg::ST_OK;
      tile_fault_nxt  = tepc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r        <= '0;
      rt_idx_r      <= '0;
      grp_r         <= '0;
      row_k_r       <= 1'b0;
      row_odd_r     <= 1'b0;
      walk_done_r   <= 1'b0;
      first_fault_r <= tepc_pkg::ST_OK;
      tile_fault_r  <= tepc_pkg::ST_OK;
    end else if (s1_fire) begin
      byte_r        <= byte_nxt;
      rt_idx_r      <= rt_idx_nxt;
      grp_r         <= grp_nxt;
      row_k_r       <= row_k_nxt;
      row_odd_r     <= row_odd_nxt;
      walk_done_r   <= walk_done_nxt;
      first_fault_r <= first_fault_nxt;
      tile_fault_r  <= tile_fault_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r)
      status_r <= status_nxt;
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.status = status_r;

  `ASSERT_CLK(a_last_gives_result, clk, rst_n, (s1_fire && s1_last_r) |=> out_valid_r)
  `ASSERT_CLK(a_last_clears_walk, clk, rst_n,
              (s1_fire && s1_last_r) |=> (byte_r == '0 && first_fault_r == tepc_pkg::ST_OK && !walk_done_r))
  `ASSERT_NEVER(a_byte_in_range, clk, rst_n, {1'b0, byte_r} >= TILE_END)
  `ASSERT_NEVER(a_done_mid_tile, clk, rst_n, walk_done_r && byte_r != '0)
  `ASSERT_NEVER(a_no_overwrite, clk, rst_n,
                s1_fire && s1_last_r && out_valid_r && !out_bus.ready)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TILE_LEN     = 136;
  localparam int unsigned RANDOM_BEATS = 200;
  localparam int unsigned CALM_FROM    = 40;
  localparam int unsigned CALM_TO      = 200;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned BURST_BEATS  = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [15:0] rows;
    logic [15:0] cols;
    int          len;
    logic [7:0]  fill;
    int          poke_at;
    logic [7:0]  poke_val;
    logic        typed;
    tepc_pkg::status_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tepc_in_if  in_bus ();
  tepc_out_if out_bus ();
  tepc_cfg_if cfg_bus ();

  tile_edge_padding_checker_top #(.TILE_BYTES(TILE_LEN)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  tepc_pkg::status_t status_q [$];
  tepc_pkg::status_t want_st;
  dir_row_t          directed_rows [11];

  // predictor state
  logic [15:0] dims_rows, dims_cols;
  int unsigned tile_pos, rtile_at, group_at;
  logic        row_kpad, row_oddnib, walk_over;
  tepc_pkg::status_t walk_fault, tile_pend;

  int unsigned errors        = 0;
  int unsigned beats_sent    = 0;
  int unsigned statuses_seen = 0;
  int unsigned cycles        = 0;
  bit          in_random     = 1'b0;
  bit          calm          = 1'b0;
  bit          hold_req      = 1'b0;
  bit          hold_used     = 1'b0;
  int unsigned hold_left     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task automatic restart_walk();
    tile_pos   = 0;
    rtile_at   = 0;
    group_at   = 0;
    row_kpad   = 1'b0;
    row_oddnib = 1'b0;
    walk_over  = 1'b0;
    walk_fault = tepc_pkg::ST_OK;
    tile_pend  = tepc_pkg::ST_OK;
  endtask

  task automatic track_beat(input logic [7:0] v, input logic is_last, input logic typed,
                            input tepc_pkg::status_t typed_st);
    int unsigned row_rem, col_rem, rt_total, groups, rr, col, used;
    logic        over, rt_at_edge, grp_at_edge, used_row;
    tepc_pkg::status_t st;
    row_rem  = dims_rows % tepc_pkg::TILE_ROWS;
    col_rem  = dims_cols % tepc_pkg::TILE_COLUMNS;
    rt_total = dims_rows / tepc_pkg::TILE_ROWS + (row_rem != 0 ? 1 : 0);
    groups   = dims_cols / tepc_pkg::TILE_COLUMNS + (col_rem != 0 ? 1 : 0);
    over = walk_over || rtile_at >= rt_total || group_at >= groups;
    if (!over) begin
      rt_at_edge  = row_rem != 0 && rtile_at + 1 == rt_total;
      grp_at_edge = col_rem != 0 && group_at + 1 == groups;
      if ((rt_at_edge || grp_at_edge) && tile_pos < tepc_pkg::SCALE_BASE) begin
        rr       = tile_pos / tepc_pkg::ROW_BYTES;
        col      = tile_pos % tepc_pkg::ROW_BYTES;
        used_row = !rt_at_edge || rr < row_rem;
        if (!used_row) begin
          if (v != 0 && tile_pend == tepc_pkg::ST_OK) tile_pend = tepc_pkg::ST_ROW_PAD;
        end else begin
          if (grp_at_edge) begin
            used = (col_rem + 1) / 2;
            if (col >= used && v != 0) row_kpad = 1'b1;
            if (col_rem % 2 == 1 && col + 1 == used && (v & tepc_pkg::HIGH_NIBBLE) != 0)
              row_oddnib = 1'b1;
          end
          if (col == tepc_pkg::ROW_BYTES - 1) begin
            // K padding wins over the odd nibble within one row
            if (tile_pend == tepc_pkg::ST_OK && row_kpad) tile_pend = tepc_pkg::ST_K_PAD;
            else if (tile_pend == tepc_pkg::ST_OK && row_oddnib) tile_pend = tepc_pkg::ST_ODD;
            row_kpad   = 1'b0;
            row_oddnib = 1'b0;
          end
        end
      end else if ((rt_at_edge || grp_at_edge) &&
                   tile_pos < tepc_pkg::SCALE_BASE + tepc_pkg::TILE_ROWS) begin
        if (rt_at_edge && tile_pos - tepc_pkg::SCALE_BASE >= row_rem && v != 0 &&
            tile_pend == tepc_pkg::ST_OK)
          tile_pend = tepc_pkg::ST_ROW_PAD;
      end
      tile_pos++;
      if (tile_pos >= TILE_LEN) begin
        tile_pos = 0;
        if (walk_fault == tepc_pkg::ST_OK) walk_fault = tile_pend;
        tile_pend  = tepc_pkg::ST_OK;
        row_kpad   = 1'b0;
        row_oddnib = 1'b0;
        group_at++;
        if (group_at >= groups) begin
          group_at = 0;
          rtile_at++;
          if (rtile_at >= rt_total) walk_over = 1'b1;
        end
      end
      over = walk_over;
    end
    if (is_last) begin
      st = walk_fault;
      if (st == tepc_pkg::ST_OK && !over && (row_rem != 0 || col_rem != 0))
        st = tepc_pkg::ST_OUTSIDE;
      status_q.push_back(typed ? typed_st : st);
      restart_walk();
    end
  endtask

  task automatic send_beat(input logic [7:0] d, input logic is_last, input logic typed,
                           input tepc_pkg::status_t typed_st);
    while (!calm && $urandom_range(99) < 33) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= d;
    in_bus.last      <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    track_beat(d, is_last, typed, typed_st);
    beats_sent++;
    calm = in_random && beats_sent >= CALM_FROM && beats_sent < CALM_TO;
    @(negedge clk);
  endtask

  // only between payloads, with the block drained
  task automatic set_dims(input logic [15:0] rows, input logic [15:0] cols);
    in_bus.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= tepc_pkg::REG_MATRIX_ROWS;
    cfg_bus.data  <= rows;
    do @(posedge clk); while (!cfg_bus.ready);
    dims_rows = rows;
    @(negedge clk);
    cfg_bus.index <= tepc_pkg::REG_MATRIX_COLUMNS;
    cfg_bus.data  <= cols;
    do @(posedge clk); while (!cfg_bus.ready);
    dims_cols = cols;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_dim(input int unsigned span);
    case ($urandom_range(15))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(span, 1));
    endcase
  endfunction

  // mostly well-formed padding with random content, some injected faults,
  // truncated walks, trailing bytes and pure noise
  task automatic random_payload();
    int unsigned row_rem, col_rem, rt_total, groups, tiles, full, odds, mode;
    int unsigned tile_no, tb, rr, col, used;
    int          len;
    logic        rt_at_edge, grp_at_edge;
    logic [7:0]  mask, v, bad;
    row_rem  = dims_rows % tepc_pkg::TILE_ROWS;
    col_rem  = dims_cols % tepc_pkg::TILE_COLUMNS;
    rt_total = dims_rows / tepc_pkg::TILE_ROWS + (row_rem != 0 ? 1 : 0);
    groups   = dims_cols / tepc_pkg::TILE_COLUMNS + (col_rem != 0 ? 1 : 0);
    tiles    = rt_total * groups;
    full     = (tiles != 0 && tiles <= 2) ? tiles * TILE_LEN : 0;
    mode     = $urandom_range(9);
    odds     = ($urandom_range(1) == 0) ? 0 : $urandom_range(200, 20);
    if (full == 0) len = $urandom_range(150, 1);
    else if (mode < 6) len = full;
    else if (mode < 8) len = $urandom_range(full, 1);
    else len = full + $urandom_range(20, 1);
    for (int b = 0; b < len; b++) begin
      mask    = 8'h00;
      tile_no = b / TILE_LEN;
      tb      = b % TILE_LEN;
      if (tile_no < tiles) begin
        rt_at_edge  = row_rem != 0 && tile_no / groups + 1 == rt_total;
        grp_at_edge = col_rem != 0 && tile_no % groups + 1 == groups;
        rr   = tb < tepc_pkg::SCALE_BASE ? tb / tepc_pkg::ROW_BYTES : tb - tepc_pkg::SCALE_BASE;
        col  = tb % tepc_pkg::ROW_BYTES;
        used = (col_rem + 1) / 2;
        if (rt_at_edge && rr >= row_rem && tb < tepc_pkg::SCALE_BASE + tepc_pkg::TILE_ROWS)
          mask = 8'hff;
        else if (grp_at_edge && tb < tepc_pkg::SCALE_BASE && col >= used)
          mask = 8'hff;
        else if (grp_at_edge && tb < tepc_pkg::SCALE_BASE && col_rem % 2 == 1 &&
                 col + 1 == used)
          mask = tepc_pkg::HIGH_NIBBLE;
      end
      v = 8'($urandom);
      if (mode != 9) begin
        v = v & ~mask;
        if (mask != 0 && odds != 0 && $urandom_range(odds - 1) == 0) begin
          do bad = 8'($urandom) & mask; while (bad == 0);
          v = v | bad;
        end
      end
      send_beat(v, b == len - 1, 1'b0, tepc_pkg::ST_OK);
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_used     <= 1'b1;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      statuses_seen++;
      if (status_q.size() == 0) begin
        report_mismatch("status beat with nothing pending", out_bus.status, -1);
      end else begin
        want_st = status_q.pop_front();
        if (out_bus.status !== want_st) report_mismatch("status", out_bus.status, want_st);
      end
    end
  end

  initial begin : stimulus
    dir_row_t r;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last      = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = tepc_pkg::REG_MATRIX_ROWS;
    cfg_bus.data     = 16'h0000;
    out_bus.ready    = 1'b0;
    dims_rows        = 16'h0000;
    dims_cols        = 16'h0000;
    restart_walk();

    //                   rows      cols      len  fill   poke  val   typed want
    directed_rows[0]  = '{16'd0,    16'd0,     1, 8'hff,  -1, 8'h00, 1'b1, tepc_pkg::ST_OK};
    directed_rows[1]  = '{16'hffff, 16'hffff,  3, 8'hff,  -1, 8'h00, 1'b1, tepc_pkg::ST_OUTSIDE};
    directed_rows[2]  = '{16'd8,    16'd32,    1, 8'hff,  -1, 8'h00, 1'b1, tepc_pkg::ST_OK};
    directed_rows[3]  = '{16'd3,    16'd32,  136, 8'h00,  80, 8'h01, 1'b1, tepc_pkg::ST_ROW_PAD};
    directed_rows[4]  = '{16'd8,    16'd5,   136, 8'h00,  35, 8'h80, 1'b1, tepc_pkg::ST_K_PAD};
    directed_rows[5]  = '{16'd8,    16'd5,   136, 8'h00,   2, 8'h10, 1'b1, tepc_pkg::ST_ODD};
    directed_rows[6]  = '{16'd1,    16'd1,   138, 8'h00, 137, 8'hff, 1'b1, tepc_pkg::ST_OK};
    directed_rows[7]  = '{16'd3,    16'd32,  136, 8'h00, 131, 8'h80, 1'b1, tepc_pkg::ST_ROW_PAD};
    directed_rows[8]  = '{16'd9,    16'd33,   20, 8'hff,  -1, 8'h00, 1'b1, tepc_pkg::ST_OUTSIDE};
    directed_rows[9]  = '{16'd12,   16'd40,   60, 8'h00,  30, 8'h5a, 1'b0, tepc_pkg::ST_OK};
    directed_rows[10] = '{16'hffff, 16'd0,     2, 8'h00,  -1, 8'h00, 1'b1, tepc_pkg::ST_OK};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      set_dims(r.rows, r.cols);
      for (int b = 0; b < r.len; b++)
        send_beat(b == r.poke_at ? r.poke_val : r.fill, b == r.len - 1, r.typed, r.want);
    end

    set_dims(pick_dim(12), pick_dim(40));
    beats_sent = 0;
    in_random  = 1'b1;
    random_payload();
    // one-beat payloads while the sink holds off: fills the block
    hold_req = 1'b1;
    repeat (BURST_BEATS) send_beat(8'($urandom), 1'b1, 1'b0, tepc_pkg::ST_OK);
    while (beats_sent < RANDOM_BEATS) begin
      if ($urandom_range(99) < 40) set_dims(pick_dim(12), pick_dim(40));
      random_payload();
    end
    in_bus.valid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* tile_edge_padding_checker_top.f */
+incdir+rtl/core
rtl/core/tepc_pkg.sv
rtl/core/tepc_if.sv
rtl/core/tile_edge_padding_checker_top.sv
sim/testbench.sv
